/* rtl/kvm_message_to_hid_events_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the input event block
// ---------------------------------------------------------------------------
`ifndef KVM_MESSAGE_TO_HID_EVENTS_MACROS_SVH
`define KVM_MESSAGE_TO_HID_EVENTS_MACROS_SVH

// Implication checked at every rising clock edge, quiet during reset.
`define KVM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define KVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/kvmhid_pkg.sv */
// ---------------------------------------------------------------------------
// kvmhid_pkg
// Shared types, message codes and helpers for the input event block.
// ---------------------------------------------------------------------------
`default_nettype none
package kvmhid_pkg;
	localparam int HeldKeysDefault = 8;

	typedef enum logic [3:0] {
		ACT_KEEPALIVE   = 4'd0,
		ACT_SCREENINFO  = 4'd1,
		ACT_ABSMOVE     = 4'd2,
		ACT_RELMOVE     = 4'd3,
		ACT_BTNDOWN     = 4'd4,
		ACT_BTNUP       = 4'd5,
		ACT_WHEEL       = 4'd6,
		ACT_PAN         = 4'd7,
		ACT_KEYDOWN     = 4'd8,
		ACT_KEYUP       = 4'd9,
		ACT_RELEASEALL  = 4'd10,
		ACT_DISCONNECT  = 4'd11
	} action_t;

	localparam logic [31:0] CODE_CALV = 32'h43414C56;
	localparam logic [31:0] CODE_QINF = 32'h51494E46;
	localparam logic [31:0] CODE_CINN = 32'h43494E4E;
	localparam logic [31:0] CODE_COUT = 32'h434F5554;
	localparam logic [31:0] CODE_DMMV = 32'h444D4D56;
	localparam logic [31:0] CODE_DMRM = 32'h444D524D;
	localparam logic [31:0] CODE_DMDN = 32'h444D444E;
	localparam logic [31:0] CODE_DMUP = 32'h444D5550;
	localparam logic [31:0] CODE_DMWM = 32'h444D574D;
	localparam logic [31:0] CODE_DKDL = 32'h444B444C;
	localparam logic [31:0] CODE_DKDN = 32'h444B444E;
	localparam logic [31:0] CODE_DKUP = 32'h444B5550;
	localparam logic [31:0] CODE_CBYE = 32'h43425945;
	localparam logic [31:0] CODE_EBSY = 32'h45425359;
	localparam logic [31:0] CODE_EUNK = 32'h45554E4B;
	localparam logic [31:0] CODE_EBAD = 32'h45424144;
	localparam logic [31:0] CODE_EICV = 32'h45494356;

	localparam int Detent = 120;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ABS,
		ST_REL,
		ST_EV1,
		ST_EV2
	} state_t;

	// message class decoded in the datapath
	typedef enum logic [3:0] {
		MSG_NONE,
		MSG_SIMPLE,
		MSG_MOTION,
		MSG_BUTTON,
		MSG_WHEEL,
		MSG_KEYDOWN,
		MSG_KEYUP,
		MSG_DRAIN
	} msg_t;

	typedef struct packed {
		logic   load;
		logic   search_step;
		logic   emit_abs;
		logic   emit_rel;
		logic   emit_ev1;
		logic   emit_ev2;
		logic   table_commit;
		logic   is_last;
	} dp_cmd_t;

	typedef struct packed {
		msg_t   kind;
		logic   search_done;
		logic   abs_pending;
		logic   rel_pending;
		logic   ev1_valid;
		logic   ev2_valid;
		logic   out_busy;
	} dp_status_t;

	function automatic logic [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767) return 16'h7FFF;
		else if (v < -17'sd32768) return 16'h8000;
		else return v[15:0];
	endfunction

	// value / 120 truncated toward zero, |value| <= 32768; zero becomes +-1
	// reciprocal estimate never runs high, one correction step settles it
	function automatic logic [15:0] detents(input logic signed [15:0] v);
		logic [15:0] mag;
		logic [31:0] prod;
		logic [8:0]  q;
		logic [15:0] r;
		mag  = v[15] ? (16'd0 - v) : v;
		prod = 32'(mag) * 32'd546;
		q    = prod[24:16];
		r    = mag - 16'(q) * 16'(Detent);
		if (r >= 16'(Detent)) q = q + 9'd1;
		if (q == 9'd0) q = 9'd1;
		return v[15] ? (16'd0 - {7'd0, q}) : {7'd0, q};
	endfunction
endpackage
`default_nettype wire

/* rtl/kvmhid_ctrl.sv */
// ---------------------------------------------------------------------------
// kvmhid_ctrl
// Sequencer: table search, then up to three result transfers per item.
// ---------------------------------------------------------------------------
`default_nettype none
module kvmhid_ctrl import kvmhid_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);
	state_t state_q, state_d;

	logic has_abs, has_rel, has_ev1, has_ev2;
	logic flush;
	assign flush   = (st.kind == MSG_DRAIN) || (st.kind == MSG_BUTTON);
	assign has_abs = flush && st.abs_pending;
	assign has_rel = flush && st.rel_pending;
	assign has_ev1 = st.ev1_valid;
	assign has_ev2 = st.ev2_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SEARCH;
			ST_SEARCH: if (st.search_done) state_d = ST_ABS;
			ST_ABS: if (!st.out_busy) state_d = ST_REL;
			ST_REL: if (!st.out_busy) state_d = ST_EV1;
			ST_EV1: if (!st.out_busy) state_d = ST_EV2;
			ST_EV2: if (!st.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SEARCH: cmd.search_step = 1'b1;
			ST_ABS: begin
				cmd.emit_abs = has_abs && !st.out_busy;
				cmd.is_last  = !has_rel && !has_ev1 && !has_ev2;
			end
			ST_REL: begin
				cmd.emit_rel = has_rel && !st.out_busy;
				cmd.is_last  = !has_ev1 && !has_ev2;
			end
			ST_EV1: begin
				cmd.emit_ev1 = has_ev1 && !st.out_busy;
				cmd.is_last  = !has_ev2;
			end
			ST_EV2: begin
				cmd.emit_ev2     = has_ev2 && !st.out_busy;
				cmd.is_last      = 1'b1;
				cmd.table_commit = !st.out_busy;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/kvmhid_dp.sv */
// ---------------------------------------------------------------------------
// kvmhid_dp
// Message decode, motion state, held-key table and output register.
// ---------------------------------------------------------------------------
`default_nettype none
module kvmhid_dp import kvmhid_pkg::*; #(
	parameter int HELD_KEYS = HeldKeysDefault
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire  [112:0] s_data,
	input  dp_cmd_t      cmd,
	output dp_status_t   st,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [39:0]  out_data
);
	localparam int IW = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
	localparam int CW = $clog2(HELD_KEYS + 1);

	// input item registers
	logic [31:0] code_q;
	logic [15:0] wa_q, wb_q, wc_q;
	logic [7:0]  usage_q;

	logic [15:0] pend_x_q, pend_y_q, sum_dx_q, sum_dy_q;
	logic        abs_pend_q;

	logic [15:0] ids_q [HELD_KEYS];
	logic [7:0]  usg_q [HELD_KEYS];
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	logic [IW-1:0] hit_q;

	msg_t kind_q;
	logic ev1_v_q, ev2_v_q;
	logic [3:0]  ev1_act_q, ev2_act_q;
	logic [15:0] ev1_x_q, ev2_x_q;

	logic        ov_q;
	logic [39:0] od_q;

	logic        search_fin;
	logic [7:0]  up_usage;

	// decode of the raw item
	msg_t        kind_d;
	logic        e1v, e2v;
	logic [3:0]  e1a, e2a;
	logic [15:0] e1x, e2x;
	logic [31:0] c;
	logic [15:0] l;
	logic signed [15:0] a, b;
	logic [7:0]  bt, us;
	always_comb begin
		c  = s_data[32:1];
		l  = s_data[48:33];
		a  = s_data[64:49];
		b  = s_data[80:65];
		bt = s_data[104:97];
		us = s_data[112:105];
		kind_d = MSG_NONE;
		e1v = 1'b0; e2v = 1'b0;
		e1a = ACT_KEEPALIVE; e2a = ACT_KEEPALIVE;
		e1x = '0; e2x = '0;
		if (s_data[0]) kind_d = MSG_DRAIN;
		else if (l >= 16'd4) begin
			unique case (c)
				CODE_CALV: begin kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_KEEPALIVE; end
				CODE_QINF: begin kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_SCREENINFO; end
				CODE_COUT: begin kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_RELEASEALL; end
				CODE_CBYE: begin kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_DISCONNECT; end
				CODE_EBSY: begin
					kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_DISCONNECT; e2x = 16'd1;
				end
				CODE_EUNK: begin
					kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_DISCONNECT; e2x = 16'd2;
				end
				CODE_EBAD: begin
					kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_DISCONNECT; e2x = 16'd3;
				end
				CODE_EICV: begin
					kind_d = MSG_SIMPLE; e2v = 1'b1; e2a = ACT_DISCONNECT; e2x = 16'd4;
				end
				CODE_CINN: if (l >= 16'd12) kind_d = MSG_MOTION;
				CODE_DMMV, CODE_DMRM: if (l >= 16'd8) kind_d = MSG_MOTION;
				CODE_DMDN, CODE_DMUP: begin
					if (l >= 16'd5 && bt >= 8'd1 && bt <= 8'd3) begin
						kind_d = MSG_BUTTON; e2v = 1'b1;
						e2a = (c == CODE_DMDN) ? ACT_BTNDOWN : ACT_BTNUP;
						e2x = {8'd0, bt};
					end
				end
				CODE_DMWM: begin
					if (l >= 16'd8) begin
						kind_d = MSG_WHEEL;
						e1v = (b != 16'sd0); e1a = ACT_WHEEL; e1x = detents(b);
						e2v = (a != 16'sd0); e2a = ACT_PAN;   e2x = detents(a);
					end
				end
				CODE_DKDL, CODE_DKDN: begin
					if (l >= 16'd10 && us != 8'd0) begin
						kind_d = MSG_KEYDOWN; e2v = 1'b1; e2a = ACT_KEYDOWN;
						e2x = {8'd0, us};
					end
				end
				CODE_DKUP: if (l >= 16'd10) begin kind_d = MSG_KEYUP; e2a = ACT_KEYUP; end
				default: ;
			endcase
		end
	end

	assign search_fin = (idx_q == count_q);

	// keyup picks its usage once the search ends
	assign up_usage = found_q ? usg_q[hit_q] : usage_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q  <= c;
			wa_q    <= a;
			wb_q    <= b;
			wc_q    <= s_data[96:81];
			usage_q <= us;
			ev1_act_q <= e1a; ev1_x_q <= e1x;
			ev2_act_q <= e2a; ev2_x_q <= e2x;
		end else if (cmd.search_step && search_fin && kind_q == MSG_KEYUP) begin
			ev2_x_q <= {8'd0, up_usage};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= MSG_NONE;
			ev1_v_q <= 1'b0;
			ev2_v_q <= 1'b0;
		end else if (cmd.load) begin
			kind_q <= kind_d;
			ev1_v_q <= e1v;
			ev2_v_q <= e2v;
		end else if (cmd.search_step && search_fin && kind_q == MSG_KEYUP) begin
			ev2_v_q <= (up_usage != 8'd0);
		end
	end

	// linear table search, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			hit_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.search_step && idx_q != count_q) begin
			if (ids_q[idx_q[IW-1:0]] == wc_q) begin
				found_q <= 1'b1;
				hit_q <= idx_q[IW-1:0];
				idx_q <= count_q;
			end else idx_q <= idx_q + 1'b1;
		end
	end

	// table update after the item's results
	logic [IW-1:0] tail;
	assign tail = IW'(count_q - 1'b1);
	always_ff @(posedge clk) begin
		if (cmd.table_commit) begin
			if (kind_q == MSG_KEYDOWN) begin
				if (found_q) usg_q[hit_q] <= usage_q;
				else if (count_q < CW'(HELD_KEYS)) begin
					ids_q[count_q[IW-1:0]] <= wc_q;
					usg_q[count_q[IW-1:0]] <= usage_q;
				end
			end else if (kind_q == MSG_KEYUP && found_q) begin
				ids_q[hit_q] <= ids_q[tail];
				usg_q[hit_q] <= usg_q[tail];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.table_commit) begin
			if (kind_q == MSG_KEYDOWN && !found_q && count_q < CW'(HELD_KEYS))
				count_q <= count_q + 1'b1;
			else if (kind_q == MSG_KEYUP && found_q) count_q <= count_q - 1'b1;
		end
	end

	// motion state; updated at the search step, emitted later from copies
	logic [15:0] fl_x_q, fl_y_q, fl_dx_q, fl_dy_q;
	logic        motion_upd;
	assign motion_upd = cmd.search_step && search_fin;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_x_q <= '0; pend_y_q <= '0; sum_dx_q <= '0; sum_dy_q <= '0;
			abs_pend_q <= 1'b0;
		end else if (motion_upd) begin
			if (kind_q == MSG_MOTION) begin
				if (code_q == CODE_DMRM) begin
					sum_dx_q <= sat16(17'(signed'(sum_dx_q)) + 17'(signed'(wa_q)));
					sum_dy_q <= sat16(17'(signed'(sum_dy_q)) + 17'(signed'(wb_q)));
				end else begin
					pend_x_q <= wa_q; pend_y_q <= wb_q; abs_pend_q <= 1'b1;
				end
			end else if (kind_q == MSG_DRAIN || kind_q == MSG_BUTTON) begin
				abs_pend_q <= 1'b0;
				sum_dx_q <= '0; sum_dy_q <= '0;
			end
		end
	end

	logic fl_abs_q, fl_rel_q;
	always_ff @(posedge clk) begin
		if (motion_upd) begin
			fl_x_q <= pend_x_q; fl_y_q <= pend_y_q;
			fl_dx_q <= sum_dx_q; fl_dy_q <= sum_dy_q;
			fl_abs_q <= abs_pend_q;
			fl_rel_q <= (sum_dx_q != '0) || (sum_dy_q != '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.emit_abs || cmd.emit_rel || cmd.emit_ev1 || cmd.emit_ev2) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_abs)
			od_q <= {3'd0, cmd.is_last, fl_y_q, fl_x_q, ACT_ABSMOVE};
		else if (cmd.emit_rel)
			od_q <= {3'd0, cmd.is_last, fl_dy_q, fl_dx_q, ACT_RELMOVE};
		else if (cmd.emit_ev1)
			od_q <= {3'd0, cmd.is_last, 16'd0, ev1_x_q, ev1_act_q};
		else if (cmd.emit_ev2)
			od_q <= {3'd0, cmd.is_last, 16'd0, ev2_x_q, ev2_act_q};
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	assign st.kind        = kind_q;
	assign st.search_done = search_fin;
	assign st.abs_pending = fl_abs_q;
	assign st.rel_pending = fl_rel_q;
	assign st.ev1_valid   = ev1_v_q;
	assign st.ev2_valid   = ev2_v_q;
	assign st.out_busy    = ov_q && !out_ready;
endmodule
`default_nettype wire

/* rtl/kvm_message_to_hid_events.sv */
// Sequencing: after the input transfer the held-key entries are compared serially (the
// full count unless a key matches earlier), then the result slots follow, one per cycle
// while m_tready does not stall the output; a result waiting on m_tready holds the sequence.
// A new item is taken only once the previous item has passed its last result slot.
// Reset: arst_n clears motion state, held-key count and output valid at once.
// ---------------------------------------------------------------------------
// kvm_message_to_hid_events
// Turns decoded remote-input messages into HID action transfers.
// ---------------------------------------------------------------------------
`default_nettype none
module kvm_message_to_hid_events import kvmhid_pkg::*; #(
	parameter int HELD_KEYS = HeldKeysDefault
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [111:0] s_tdata,  // msg_code, msg_len, word_a, word_b, word_c, button_byte, key_usage
	input  wire          s_tuser,  // func
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [39:0]  m_tdata,  // action, value_x, value_y, zero pad
	output logic         m_tlast
);
	dp_cmd_t    cmd;
	dp_status_t st;
	logic [39:0] od;

	kvmhid_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.st(st), .cmd(cmd)
	);

	kvmhid_dp #(.HELD_KEYS(HELD_KEYS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.s_data({s_tdata, s_tuser}),
		.cmd(cmd), .st(st),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
	);

	assign m_tdata = {4'd0, od[35:0]};
	assign m_tlast = od[36];
endmodule
`default_nettype wire

/* rtl/kvmhid_checker.sv */
// ---------------------------------------------------------------------------
// kvmhid_checker
// Port-level checks for the input event block.
// ---------------------------------------------------------------------------
`default_nettype none
`include "kvm_message_to_hid_events_macros.svh"
module kvmhid_checker import kvmhid_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast
);
	`KVM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`KVM_ASSERT_IMPL(a_action_range, clk, arst_n, m_tvalid, m_tdata[3:0] <= 4'd11, "action code out of range")
	`KVM_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	`KVM_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[39:36] == 4'd0, "pad bits set")
endmodule
bind kvm_message_to_hid_events kvmhid_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

/* dv/kvm_message_to_hid_events_test.sv */
// ---------------------------------------------------------------------------
// kvm_message_to_hid_events_test
// Self-checking bench: a directed table, then weighted random message
// sequences. Every result transfer is compared against a predictor of the
// message interpreter, with random stalls on both sides.
// ---------------------------------------------------------------------------
`default_nettype none
module kvm_message_to_hid_events_test;
	import kvmhid_pkg::*;

	localparam logic [31:0] CODE_CNOP = "CNOP";
	localparam logic [31:0] CODE_CIAK = "CIAK";
	localparam logic [31:0] CODE_DKRP = "DKRP";
	localparam logic [31:0] CODE_LSYN = "LSYN";
	localparam int N_RANDOM = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic        func;
		logic [31:0] code;
		logic [15:0] len;
		logic [15:0] wa;
		logic [15:0] wb;
		logic [15:0] wc;
		logic [7:0]  btn;
		logic [7:0]  usage;
	} msg_item_t;

	typedef struct {
		action_t            act;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} hid_action_t;

	typedef struct {
		logic        func;
		logic [31:0] code;
		logic [15:0] len;
		logic [15:0] wa;
		logic [15:0] wb;
		logic [15:0] wc;
		logic [7:0]  usage;
		bit          chk;
		action_t     exp_act;
		int          exp_x;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;
	logic         m_tlast;

	kvm_message_to_hid_events dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	hid_action_t pending_actions[$];
	int          errors;
	int          cycles;
	bit          hold_request;
	bit          holding;

	// predictor state
	logic signed [15:0] abs_x, abs_y;
	bit                 abs_valid;
	logic signed [15:0] rel_x, rel_y;
	logic [15:0]        key_ids[8];
	logic [7:0]         key_usages[8];
	int                 key_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[kvm_message_to_hid_events] ERROR");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch @%0d: %s", cycles, what);
		errors++;
	endtask

	task automatic push_action(input action_t act, input int x, input int y);
		hid_action_t r;
		r.act = act;
		r.x = 16'(x);
		r.y = 16'(y);
		r.last = 1'b0;
		pending_actions.push_back(r);
	endtask

	function automatic int wheel_steps(input int v);
		int q;
		q = v / 120;
		if (q != 0) return q;
		return v > 0 ? 1 : -1;
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	task automatic flush_pointer();
		if (abs_valid) begin
			push_action(ACT_ABSMOVE, int'(abs_x), int'(abs_y));
			abs_valid = 0;
		end
		if (rel_x != 0 || rel_y != 0) begin
			push_action(ACT_RELMOVE, int'(rel_x), int'(rel_y));
			rel_x = '0;
			rel_y = '0;
		end
	endtask

	// returns number of actions queued for this message
	task automatic predict_actions(input msg_item_t m, output int n);
		int                 n_prior;
		int                 i;
		int                 hit;
		logic [7:0]         u;
		logic signed [15:0] a, b;
		n_prior = pending_actions.size();
		a = m.wa;
		b = m.wb;
		if (m.func) begin
			flush_pointer();
		end else if (m.len >= 4) begin
			case (m.code)
				CODE_CALV: push_action(ACT_KEEPALIVE, 0, 0);
				CODE_QINF: push_action(ACT_SCREENINFO, 0, 0);
				CODE_COUT: push_action(ACT_RELEASEALL, 0, 0);
				CODE_CINN, CODE_DMMV: begin
					if (m.len >= (m.code == CODE_CINN ? 12 : 8)) begin
						abs_x = a;
						abs_y = b;
						abs_valid = 1;
					end
				end
				CODE_DMRM: begin
					if (m.len >= 8) begin
						rel_x = clamp16(int'(rel_x) + int'(a));
						rel_y = clamp16(int'(rel_y) + int'(b));
					end
				end
				CODE_DMDN, CODE_DMUP: begin
					if (m.len >= 5 && m.btn >= 1 && m.btn <= 3) begin
						flush_pointer();
						push_action(m.code == CODE_DMDN ? ACT_BTNDOWN : ACT_BTNUP,
							int'(m.btn), 0);
					end
				end
				CODE_DMWM: begin
					if (m.len >= 8) begin
						if (b != 0) push_action(ACT_WHEEL, wheel_steps(int'(b)), 0);
						if (a != 0) push_action(ACT_PAN, wheel_steps(int'(a)), 0);
					end
				end
				CODE_DKDL, CODE_DKDN: begin
					if (m.len >= 10 && m.usage != 0) begin
						hit = 0;
						for (i = 0; i < key_count; i++)
							if (!hit && key_ids[i] == m.wc) begin
								key_usages[i] = m.usage;
								hit = 1;
							end
						if (!hit && key_count < 8) begin
							key_ids[key_count] = m.wc;
							key_usages[key_count] = m.usage;
							key_count++;
						end
						push_action(ACT_KEYDOWN, int'(m.usage), 0);
					end
				end
				CODE_DKUP: begin
					if (m.len >= 10) begin
						u = '0;
						hit = 0;
						for (i = 0; i < key_count; i++)
							if (!hit && key_ids[i] == m.wc) begin
								u = key_usages[i];
								key_ids[i] = key_ids[key_count - 1];
								key_usages[i] = key_usages[key_count - 1];
								hit = 1;
							end
						if (hit) key_count--;
						if (u == 0) u = m.usage;
						if (u != 0) push_action(ACT_KEYUP, int'(u), 0);
					end
				end
				CODE_CBYE: push_action(ACT_DISCONNECT, 0, 0);
				CODE_EBSY: push_action(ACT_DISCONNECT, 1, 0);
				CODE_EUNK: push_action(ACT_DISCONNECT, 2, 0);
				CODE_EBAD: push_action(ACT_DISCONNECT, 3, 0);
				CODE_EICV: push_action(ACT_DISCONNECT, 4, 0);
				default: ;
			endcase
		end
		n = pending_actions.size() - n_prior;
		if (n > 0) pending_actions[pending_actions.size() - 1].last = 1'b1;
	endtask

	task automatic send_message(input msg_item_t m, output int n);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= m.func;
		s_tdata <= {m.usage, m.btn, m.wc, m.wb, m.wa, m.len, m.code};
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		predict_actions(m, n);
	endtask

	task automatic idle_sender(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic msg_item_t random_message();
		msg_item_t m;
		int        pick;
		m.func = 1'b0;
		m.wa = 16'($urandom);
		m.wb = 16'($urandom);
		m.wc = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
		m.usage = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom);
		m.len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(12, 40));
		pick = $urandom_range(0, 99);
		if (pick < 8) m.func = 1'b1;
		if (pick < 18) m.code = CODE_DMRM;
		else if (pick < 26) m.code = CODE_DMMV;
		else if (pick < 30) m.code = CODE_CINN;
		else if (pick < 40) begin
			m.code = $urandom_range(0, 1) ? CODE_DMDN : CODE_DMUP;
			m.wa[15:8] = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
		end
		else if (pick < 48) begin
			m.code = CODE_DMWM;
			if ($urandom_range(0, 3) == 0) m.wa = '0;
			if ($urandom_range(0, 3) == 0) m.wb = 16'($urandom_range(0, 240)) - 16'd120;
		end
		else if (pick < 62) m.code = $urandom_range(0, 1) ? CODE_DKDN : CODE_DKDL;
		else if (pick < 74) m.code = CODE_DKUP;
		else if (pick < 86) begin
			case ($urandom_range(0, 8))
				0: m.code = CODE_CALV;
				1: m.code = CODE_QINF;
				2: m.code = CODE_COUT;
				3: m.code = CODE_CBYE;
				4: m.code = CODE_EBSY;
				5: m.code = CODE_EUNK;
				6: m.code = CODE_EBAD;
				7: m.code = CODE_EICV;
				default: m.code = CODE_LSYN;
			endcase
		end
		else if (pick < 92) begin
			m.code = ($urandom_range(0, 1)) ? CODE_DKRP : CODE_CIAK;
		end
		else begin
			m.code = $urandom;
			m.len = 16'($urandom_range(0, 11));
			if ($urandom_range(0, 1)) m.code = CODE_DMRM;
		end
		m.btn = m.wa[15:8];
		return m;
	endfunction

	// receiver: random stall pattern, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		holding = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !holding) begin
				holding = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
				holding = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		hid_action_t got;
		hid_action_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.act = action_t'(m_tdata[3:0]);
			got.x = m_tdata[19:4];
			got.y = m_tdata[35:20];
			got.last = m_tlast;
			if (pending_actions.size() == 0) begin
				report($sformatf("unexpected transfer action %0d", m_tdata[3:0]));
			end else begin
				want = pending_actions.pop_front();
				if (got.act != want.act)
					report($sformatf("action %0d, want %0d", got.act, want.act));
				if (got.x != want.x)
					report($sformatf("value_x %0d, want %0d", got.x, want.x));
				if (got.y != want.y)
					report($sformatf("value_y %0d, want %0d", got.y, want.y));
				if (got.last != want.last)
					report($sformatf("last %0d, want %0d", got.last, want.last));
			end
		end
	end

	row_t rows[] = '{
		'{0, CODE_CALV, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_KEEPALIVE, 0},
		'{0, CODE_QINF, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_SCREENINFO, 0},
		'{0, CODE_CALV, 16'd3,     16'h0000, 16'h0000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_COUT, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_RELEASEALL, 0},
		'{0, CODE_CBYE, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_DISCONNECT, 0},
		'{0, CODE_EBSY, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_DISCONNECT, 1},
		'{0, CODE_EUNK, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_DISCONNECT, 2},
		'{0, CODE_EBAD, 16'd4,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_DISCONNECT, 3},
		'{0, CODE_EICV, 16'd65535, 16'hFFFF, 16'hFFFF, 16'hFFFF,  8'hFF,  1, ACT_DISCONNECT, 4},
		'{0, CODE_CINN, 16'd12,    16'h8000, 16'h7FFF, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMRM, 16'd8,     16'h7FFF, 16'h8000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMRM, 16'd8,     16'h7FFF, 16'h8000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMUP, 16'd5,     16'h0400, 16'h0000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMDN, 16'd5,     16'h0100, 16'h0000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMMV, 16'd8,     16'h7FFF, 16'hFFFF, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{1, CODE_CALV, 16'd0,     16'h0000, 16'h0000, 16'd0,     8'd0,   1, ACT_ABSMOVE, 32767},
		'{1, 32'd0,     16'd0,     16'h0000, 16'h0000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMWM, 16'd8,     16'h8000, 16'd119,  16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMWM, 16'd8,     16'hFFFF, 16'hFF10, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DKDL, 16'd10,    16'h0000, 16'h0000, 16'hFFFF,  8'hFF,  1, ACT_KEYDOWN, 255},
		'{0, CODE_DKDN, 16'd10,    16'h0000, 16'h0000, 16'h0000,  8'h01, 1, ACT_KEYDOWN, 1},
		'{0, CODE_DKUP, 16'd10,    16'h0000, 16'h0000, 16'hFFFF,  8'h00, 1, ACT_KEYUP, 255},
		'{0, CODE_DKUP, 16'd10,    16'h0000, 16'h0000, 16'h0007,  8'h00, 0, ACT_KEEPALIVE, 0},
		'{0, CODE_CNOP, 16'd20,    16'h0000, 16'h0000, 16'd0,     8'd0,   0, ACT_KEEPALIVE, 0},
		'{0, CODE_DMUP, 16'd5,     16'h0300, 16'h0000, 16'd0,     8'd0,   1, ACT_BTNUP, 3}
	};

	initial begin
		msg_item_t m;
		int        n;
		int        k;
		int        burst;
		errors = 0;
		cycles = 0;
		hold_request = 1'b0;
		abs_x = '0; abs_y = '0; abs_valid = 0;
		rel_x = '0; rel_y = '0;
		key_count = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			m.func = rows[i].func;
			m.code = rows[i].code;
			m.len = rows[i].len;
			m.wa = rows[i].wa;
			m.wb = rows[i].wb;
			m.wc = rows[i].wc;
			m.btn = rows[i].wa[15:8];
			m.usage = rows[i].usage;
			send_message(m, n);
			if (rows[i].chk && (n < 1 ||
					pending_actions[pending_actions.size() - n].act != rows[i].exp_act ||
					pending_actions[pending_actions.size() - n].x != 16'(rows[i].exp_x)))
				report($sformatf("directed row %0d predicts wrong first action", i));
			if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 6));
		end

		k = 0;
		while (k < N_RANDOM) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				if (k == 40) hold_request = 1'b1;
				if (k == 150) begin
					idle_sender(0);
					while (pending_actions.size() != 0) @(posedge clk);
				end
				m = random_message();
				send_message(m, n);
				k++;
			end
			if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 15));
		end
		idle_sender(0);

		while (pending_actions.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[kvm_message_to_hid_events] OK");
		else
			$display("[kvm_message_to_hid_events] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
